>>> hw/rtl/scalar_kalman_filter_multichannel_defines.svh
// Assertion macros for the checker file of the scalar Kalman filter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SCALAR_KALMAN_FILTER_MULTICHANNEL_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_MULTICHANNEL_DEFINES_SVH

// same-cycle implication
`define SKF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/skf_pkg.sv
// Package for the multichannel scalar Kalman filter: widths, FSM state type,
// controller/datapath command and status structs. No dependencies.
package skf_pkg;

  localparam int unsigned CH_W         = 3;
  localparam int unsigned CH_SPAN      = 2 ** CH_W;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned GAIN_W       = 17;
  localparam int unsigned DIV_STEPS    = GAIN_W;
  localparam int unsigned CNT_W        = $clog2(DIV_STEPS);
  localparam int unsigned CHANNELS_DEF = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_COV,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_est;
    logic mul_cov;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
  } sts_t;

endpackage

>>> hw/rtl/skf_ctrl.sv
// Kalman sequencer, uses skf_pkg: steps one request through prior, gain
// division, two multiplies and table write-back for an in-range channel.
module skf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  skf_pkg::sts_t sts,
  output skf_pkg::cmd_t cmd
);

  skf_pkg::state_t state_r, state_nxt;
  logic [skf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      skf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = skf_pkg::ST_PREP;
        end
      end
      skf_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.ch_ok ? skf_pkg::ST_DIV : skf_pkg::ST_COMMIT;
      end
      skf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
          state_nxt = skf_pkg::ST_MUL_EST;
        end
      end
      skf_pkg::ST_MUL_EST: begin
        cmd.mul_est = 1'b1;
        state_nxt   = skf_pkg::ST_MUL_COV;
      end
      skf_pkg::ST_MUL_COV: begin
        cmd.mul_cov = 1'b1;
        state_nxt   = skf_pkg::ST_COMMIT;
      end
      skf_pkg::ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/skf_dp.sv
// Datapath of the Kalman filter: per-channel estimate/covariance tables,
// restoring gain divider, shared 18x33 multiplier, result register. Uses skf_pkg.
module skf_dp #(
  parameter int unsigned CHANNELS = skf_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  skf_pkg::cmd_t                     cmd,
  output skf_pkg::sts_t                     sts,
  input  logic        [skf_pkg::CH_W-1:0]   in_channel,
  input  logic signed [skf_pkg::DATA_W-1:0] in_sample,
  input  logic        [skf_pkg::DATA_W-1:0] in_process_noise,
  input  logic        [skf_pkg::DATA_W-1:0] in_measure_noise,
  output logic        [skf_pkg::CH_W-1:0]   out_channel_out,
  output logic signed [skf_pkg::DATA_W-1:0] out_estimate
);

  localparam int unsigned DW    = skf_pkg::DATA_W;
  localparam int unsigned GW    = skf_pkg::GAIN_W;
  localparam int unsigned FRAC  = GW - 1;
  localparam int unsigned PW    = GW + DW + 2;
  localparam int unsigned DEPTH = (CHANNELS < skf_pkg::CH_SPAN) ? CHANNELS : skf_pkg::CH_SPAN;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        [skf_pkg::CH_W-1:0] ch_r;
  logic signed [DW-1:0]            smp_r;
  logic        [DW-1:0]            q_r;
  logic        [DW-1:0]            rn_r;
  logic signed [DW-1:0]            est_r;
  logic        [DW-1:0]            prior_r;
  logic        [DW:0]              denom_r;
  logic        [DW+1:0]            rem_r;
  logic        [GW-1:0]            quo_r;
  logic signed [PW-1:0]            prod_r;
  logic signed [DW-1:0]            nest_r;
  logic signed [DW-1:0]            est_tab_r [DEPTH];
  logic        [DW-1:0]            cov_tab_r [DEPTH];
  logic        [skf_pkg::CH_W-1:0] out_ch_r;
  logic signed [DW-1:0]            out_est_r;

  logic [IDX_W-1:0] idx;
  logic             ch_ok;
  logic [DW:0]      psum;
  logic [DW-1:0]    prior_nxt;
  logic             rem_ge;
  logic [DW+1:0]    rem_sub;
  logic [DW+1:0]    rem_nxt;
  logic [GW-1:0]    quo_nxt;
  logic [GW-1:0]    gain;
  logic signed [DW:0]   diff;
  logic [GW-1:0]        mul_a;
  logic signed [DW:0]   mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] rnd;
  logic signed [PW-FRAC-1:0] corr;
  logic signed [PW-FRAC:0]   nest_wide;
  logic signed [DW-1:0] nest_nxt;
  logic [DW-1:0]        cov_nxt;

  assign idx   = ch_r[IDX_W-1:0];
  assign ch_ok = ({1'b0, ch_r} < (skf_pkg::CH_W + 1)'(DEPTH));
  assign sts.ch_ok = ch_ok;

  // prior = covariance + Q, saturating
  assign psum      = {1'b0, cov_tab_r[idx]} + {1'b0, q_r};
  assign prior_nxt = psum[DW] ? '1 : psum[DW-1:0];

  // restoring division, one quotient bit per step
  assign rem_ge  = (rem_r >= {1'b0, denom_r});
  assign rem_sub = rem_ge ? (rem_r - {1'b0, denom_r}) : rem_r;
  assign rem_nxt = {rem_sub[DW:0], 1'b0};
  assign quo_nxt = {quo_r[GW-2:0], rem_ge};
  assign gain    = (denom_r == '0) ? '0 : quo_r;

  assign diff     = {smp_r[DW-1], smp_r} - {est_r[DW-1], est_r};
  assign mul_a    = cmd.mul_cov ? (GW'(1) << FRAC) - gain : gain;
  assign mul_b    = cmd.mul_cov ? $signed({1'b0, prior_r}) : diff;
  assign prod_nxt = $signed({1'b0, mul_a}) * mul_b;

  // round half up, then floor by the fraction shift
  assign rnd       = prod_r + $signed(PW'(1) << (FRAC - 1));
  assign corr      = $signed(rnd[PW-1:FRAC]);
  assign nest_wide = {{(PW-FRAC+1-DW){est_r[DW-1]}}, est_r} + {corr[PW-FRAC-1], corr};
  assign cov_nxt   = rnd[DW+FRAC-1:FRAC];

  always_comb begin
    if (!nest_wide[PW-FRAC] && (|nest_wide[PW-FRAC-1:DW-1])) begin
      nest_nxt = {1'b0, {(DW-1){1'b1}}};
    end else if (nest_wide[PW-FRAC] && !(&nest_wide[PW-FRAC-1:DW-1])) begin
      nest_nxt = {1'b1, {(DW-1){1'b0}}};
    end else begin
      nest_nxt = nest_wide[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r  <= in_channel;
      smp_r <= in_sample;
      q_r   <= in_process_noise;
      rn_r  <= in_measure_noise;
    end
    if (cmd.prep) begin
      est_r   <= est_tab_r[idx];
      prior_r <= prior_nxt;
      denom_r <= {1'b0, prior_nxt} + {1'b0, rn_r};
      rem_r   <= {2'b00, prior_nxt};
      quo_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.mul_est || cmd.mul_cov) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_cov) begin
      nest_r <= nest_nxt;
    end
    if (cmd.commit) begin
      out_ch_r  <= ch_r;
      out_est_r <= ch_ok ? nest_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        est_tab_r[i] <= '0;
        cov_tab_r[i] <= '0;
      end
    end else if (cmd.commit && ch_ok) begin
      est_tab_r[idx] <= nest_r;
      cov_tab_r[idx] <= cov_nxt;
    end
  end

  assign out_channel_out = out_ch_r;
  assign out_estimate    = out_est_r;

endmodule

>>> hw/rtl/scalar_kalman_filter_multichannel.sv
// Multichannel scalar Kalman filter, top level. Takes one request at a time:
// it captures the request, forms the prior, runs the gain divider (one quotient
// bit per cycle, the step that sets the rate), uses the shared multiplier twice
// and writes back once the previous result has been taken. A request for a
// channel beyond CHANNELS goes from the prior straight to write-back (estimate
// reported as 0, no state change). The result sits in an output register, so
// the next request is taken while it waits. Both tables read as zero after reset.
// Depends on skf_pkg, skf_ctrl and skf_dp.
module scalar_kalman_filter_multichannel #(
  parameter int unsigned CHANNELS = skf_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic        [skf_pkg::CH_W-1:0]   in_channel,
  input  logic signed [skf_pkg::DATA_W-1:0] in_sample,
  input  logic        [skf_pkg::DATA_W-1:0] in_process_noise,
  input  logic        [skf_pkg::DATA_W-1:0] in_measure_noise,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [skf_pkg::CH_W-1:0]   out_channel_out,
  output logic signed [skf_pkg::DATA_W-1:0] out_estimate
);

  skf_pkg::cmd_t cmd;
  skf_pkg::sts_t sts;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  skf_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .in_process_noise (in_process_noise),
    .in_measure_noise (in_measure_noise),
    .out_channel_out  (out_channel_out),
    .out_estimate     (out_estimate)
  );

endmodule

>>> hw/rtl/skf_checker.sv
// Port-level checks for the Kalman filter top level, bound in below.
// Depends on skf_pkg and scalar_kalman_filter_multichannel_defines.svh.
`include "scalar_kalman_filter_multichannel_defines.svh"

module skf_checker #(
  parameter int unsigned CHANNELS = skf_pkg::CHANNELS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [skf_pkg::CH_W-1:0]   out_channel_out,
  input logic [skf_pkg::DATA_W-1:0] out_estimate
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r, pend_nxt;
  logic       ch_beyond;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign pend_nxt  = pend_r + {1'b0, in_acc} - {1'b0, out_acc};
  assign ch_beyond = (int'(out_channel_out) >= CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SKF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_estimate) && $stable(out_channel_out), "result changed while stalled")
  `SKF_ASSERT_NEXT(a_one_at_a_time, in_acc, !in_ready, "request taken while one is in work")
  `SKF_ASSERT_NOW(a_no_phantom, out_acc, pend_r != 2'd0, "result without a request")
  `SKF_ASSERT_NOW(a_beyond_zero, out_valid && ch_beyond, out_estimate == '0, "unknown channel gave nonzero estimate")

endmodule

bind scalar_kalman_filter_multichannel skf_checker #(
  .CHANNELS (CHANNELS)
) u_skf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_channel_out (out_channel_out),
  .out_estimate    (out_estimate)
);
